// ===== hw/rtl/olad_pkg.sv =====
// Package: sizes, codes and shared types of the ordered list block.
`default_nettype none

package olad_pkg;

	localparam int CAPACITY  = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int RES_OCC_W = $clog2(RES_DEPTH + 1);

	localparam logic [1:0] CMD_APPEND   = 2'd0;
	localparam logic [1:0] CMD_DELETE   = 2'd1;
	localparam logic [1:0] CMD_TRAVERSE = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SINGLE,
		S_DEL,
		S_TRAV
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element_value;
		status_t                  status;
		logic                     last_of_run;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [RES_OCC_W-1:0] occ;
		logic                 pop;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/olad_if.sv =====
// Interfaces: command channel and result channel with valid/ready.
`default_nettype none

interface olad_cmd_if import olad_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic signed [DATA_W-1:0] operand_value;

	modport source (output valid, command, operand_value, input ready);
	modport sink   (input valid, command, operand_value, output ready);
endinterface

interface olad_res_if import olad_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element_value;
	logic [1:0]               status;
	logic                     last_of_run;

	modport source (output valid, element_value, status, last_of_run, input ready);
	modport sink   (input valid, element_value, status, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/olad_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
`default_nettype none

module olad_ram #(
	parameter  int DEPTH = 16,
	parameter  int WIDTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/olad_res_fifo.sv =====
// Two-entry result queue that drives the result channel.
`default_nettype none

module olad_res_fifo import olad_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire result_t    push_res,
	output      fifo_stat_t fifo_stat,
	olad_res_if.source      rsp
);

	result_t              entry_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_OCC_W-1:0] occ_q;
	logic                 pop;

	assign pop               = rsp.valid && rsp.ready;
	assign rsp.valid         = (occ_q != '0);
	assign rsp.element_value = entry_q[rd_ptr_q].element_value;
	assign rsp.status        = entry_q[rd_ptr_q].status;
	assign rsp.last_of_run   = entry_q[rd_ptr_q].last_of_run;
	assign fifo_stat.occ     = occ_q;
	assign fifo_stat.pop     = pop;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   occ_q <= occ_q + RES_OCC_W'(1);
				2'b01:   occ_q <= occ_q - RES_OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/olad_ctrl.sv =====
// Sequencer: accepts commands, walks the element store, emits results.
`default_nettype none

module olad_ctrl import olad_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	olad_cmd_if.sink               req,
	input  wire fifo_stat_t        fifo_stat,
	output      logic              push,
	output      result_t           push_res,
	output      mem_req_t          mem_req,
	input  wire logic [DATA_W-1:0] rd_data
);

	state_t                   state_q, state_d;
	logic signed [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         idx_q;
	logic                     rd_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic                     found_q;
	status_t                  stat_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     room;
	logic                     credit;
	logic                     issue_ok;
	logic                     rd_issue;
	logic                     scan_done;
	logic                     match;
	logic                     last_hit;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign room      = (fifo_stat.occ < RES_OCC_W'(RES_DEPTH));
	// true if a queue slot is left once the read in flight lands, counting this cycle's pop
	assign credit    = ({1'b0, fifo_stat.occ} + (RES_OCC_W+1)'(rd_s1))
	                 < ((RES_OCC_W+1)'(RES_DEPTH) + (RES_OCC_W+1)'(fifo_stat.pop));
	assign issue_ok  = (idx_q < count_q);
	assign scan_done = (idx_q == count_q) && !rd_s1;
	assign match     = (rd_data == val_q);
	assign last_hit  = ((CNT_W'(addr_s1) + CNT_W'(1)) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (req.command == CMD_DELETE && !empty) begin
						state_d = S_DEL;
					end else if (req.command == CMD_TRAVERSE && !empty) begin
						state_d = S_TRAV;
					end else begin
						state_d = S_SINGLE;
					end
				end
			end
			S_SINGLE: begin
				if (room) begin
					state_d = S_IDLE;
				end
			end
			S_DEL: begin
				if (scan_done) begin
					state_d = S_SINGLE;
				end
			end
			S_TRAV: begin
				if (scan_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		push                   = 1'b0;
		push_res.element_value = '0;
		push_res.status        = STAT_OK;
		push_res.last_of_run   = 1'b1;
		rd_issue               = 1'b0;
		mem_req.we             = 1'b0;
		mem_req.waddr          = addr_s1 - ADDR_W'(1);
		mem_req.wdata          = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.command == CMD_APPEND && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = count_q[ADDR_W-1:0];
					mem_req.wdata = req.operand_value;
				end
			end
			S_SINGLE: begin
				push            = room;
				push_res.status = stat_q;
			end
			S_DEL: begin
				rd_issue = issue_ok;
				// past the match, each element moves down one slot
				mem_req.we = rd_s1 && found_q;
			end
			S_TRAV: begin
				rd_issue = issue_ok && credit;
				if (rd_s1) begin
					push                   = 1'b1;
					push_res.element_value = rd_data;
					push_res.last_of_run   = last_hit;
				end
			end
			default: begin
			end
		endcase
		mem_req.re    = rd_issue;
		mem_req.raddr = idx_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= req.operand_value;
		end
		addr_s1 <= idx_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			found_q <= 1'b0;
			stat_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_issue;
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				priority if (req.command == CMD_APPEND) begin
					stat_q <= full ? STAT_FULL : STAT_OK;
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else if (req.command == CMD_DELETE || req.command == CMD_TRAVERSE) begin
					stat_q <= empty ? STAT_EMPTY : STAT_OK;
				end else begin
					stat_q <= STAT_OK;
				end
			end else begin
				if (rd_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (state_q == S_DEL && rd_s1 && !found_q && match) begin
					found_q <= 1'b1;
				end
				if (state_q == S_DEL && scan_done) begin
					stat_q <= found_q ? STAT_OK : STAT_NOT_FOUND;
					if (found_q) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
			end
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_stat.occ < RES_OCC_W'(RES_DEPTH) || fifo_stat.pop))
		else $error("result pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("read and write of the same entry in one cycle");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL && rd_s1 && found_q) |-> (addr_s1 != '0))
		else $error("compaction write below entry zero");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!rd_s1 && !rd_issue))
		else $error("store read in flight while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_append_delete_top.sv =====
// Top level of the ordered list block: sequencer, element store, result queue.
`default_nettype none

// Ordered list of up to CAPACITY (16) signed 32-bit values held in one
// synchronous RAM, head at entry 0, with a live element count. Commands are
// taken one at a time: req.ready is high only while the sequencer is idle.
// Append (command 0) writes the tail entry in the accept cycle and returns one
// result (ok or full) once the result queue has room. Delete (command 1)
// streams entries 0..n-1 through the single RAM read port, one per cycle; once
// the first match has gone by, every later entry is written back one slot
// lower, so search and compaction share one pass. One result follows (ok,
// empty or not found). Traverse (command 2) streams the same way and delivers
// one transfer per element, last_of_run on the tail, its reads held back
// while the result queue has no slot; an empty list gives a single transfer
// with status empty. Command 3 changes nothing and returns one ok transfer.
// Results pass through a two-entry queue, so a finished result may wait on
// rsp while the next command is accepted; rsp.ready low stalls a traverse
// without loss. On single-result transfers element_value reads zero and
// last_of_run is high; status ok goes with every traversed element.
// The store needs no clearing after reset: only entries below the count are
// ever read, and each of those has been written.
module ordered_list_append_delete_top import olad_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	olad_cmd_if.sink   req,
	olad_res_if.source rsp
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] rd_data;
	fifo_stat_t        fifo_stat;
	logic              push;
	result_t           push_res;

	olad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_res  (push_res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	// element store, one write and one read port
	olad_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	olad_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.fifo_stat (fifo_stat),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
